@@ src/dam_pkg.sv @@
package dam_pkg;

    // word and counter widths fixed by the instruction format
    localparam int WORD_W = 15;
    localparam int MAG_W  = 14;
    localparam int PC_W   = 7;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = 15'sd9999;
    localparam t_word WORD_MIN = -15'sd9999;

    // request modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_EXEC    = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_RESTART = 2'd3;

    // run status codes
    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_HALT   = 3'd1;
    localparam logic [2:0] ST_RANOFF = 3'd2;
    localparam logic [2:0] ST_DIVZ   = 3'd3;
    localparam logic [2:0] ST_OVF    = 3'd4;

    // opcodes
    localparam logic [6:0] OP_READ       = 7'd10;
    localparam logic [6:0] OP_WRITE      = 7'd11;
    localparam logic [6:0] OP_LOAD       = 7'd20;
    localparam logic [6:0] OP_STORE      = 7'd21;
    localparam logic [6:0] OP_ADD        = 7'd30;
    localparam logic [6:0] OP_SUB        = 7'd31;
    localparam logic [6:0] OP_DIV        = 7'd32;
    localparam logic [6:0] OP_MUL        = 7'd33;
    localparam logic [6:0] OP_BRANCH     = 7'd40;
    localparam logic [6:0] OP_BRANCHNEG  = 7'd41;
    localparam logic [6:0] OP_BRANCHZERO = 7'd42;
    localparam logic [6:0] OP_HALT       = 7'd43;

    // x / 100 == (x * 5243) >> 19 for all x below 43699
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;
    localparam logic [13:0] HUNDRED   = 14'd100;

    // memory read address select
    typedef enum logic [1:0] {
        RS_ADDR = 2'd0,
        RS_PC   = 2'd1,
        RS_OPD  = 2'd2
    } t_rsel;

    // controller to datapath
    typedef struct packed {
        logic  latch;
        logic  rd_en;
        t_rsel rd_sel;
        logic  load_we;
        logic  restart;
        logic  ranoff;
        logic  divz;
        logic  decode;
        logic  split;
        logic  exec;
        logic  div_start;
        logic  div_take;
        logic  commit;
        logic  load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       running;
        logic       pc_ok;
        logic       is_div;
        logic       m_zero;
        logic       div_done;
    } t_sts;

endpackage

@@ src/dam_div.sv @@
module dam_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  dam_pkg::t_word i_dividend,
    input  dam_pkg::t_word i_divisor,
    output logic           o_done,
    output dam_pkg::t_word o_quotient
);
    import dam_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [MAG_W-1:0] r_quo;
    logic [MAG_W-1:0] r_dm;
    logic             r_neg;

    logic [WORD_W-1:0] trial;
    logic              fits;

    // magnitude of an in-range word
    function automatic logic [MAG_W-1:0] mag(input t_word v);
        t_word neg_v;
        neg_v = -v;
        return v[WORD_W-1] ? neg_v[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem[MAG_W-1:0], r_quo[MAG_W-1]};
        fits  = trial >= {1'b0, r_dm};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag(i_dividend);
            r_dm  <= mag(i_divisor);
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dm}) : trial;
            r_quo <= {r_quo[MAG_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

@@ src/dam_dpath.sv @@
module dam_dpath #(
    parameter int MEMORY_WORDS = 100
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dam_pkg::t_cmd  i_cmd,
    output dam_pkg::t_sts  o_sts,
    input  logic [1:0]     i_mode,
    input  logic [6:0]     i_address,
    input  dam_pkg::t_word i_word,
    input  dam_pkg::t_word i_read_input,
    output logic [6:0]     o_program_counter,
    output dam_pkg::t_word o_accumulator,
    output logic [2:0]     o_status,
    output logic           o_write_valid,
    output dam_pkg::t_word o_write_value,
    output dam_pkg::t_word o_read_data
);
    import dam_pkg::*;

    localparam int         AW    = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
    localparam logic [6:0] MEM_N = 7'(MEMORY_WORDS);

    // latched request
    logic [1:0] r_mode;
    logic [6:0] r_addr;
    t_word      r_word;
    t_word      r_rin;

    // machine state
    t_word           r_acc;
    logic [PC_W-1:0] r_pc;
    logic [2:0]      r_status;

    // instruction decode and execution
    logic [MAG_W-1:0]   r_w;
    logic [6:0]         r_q;
    logic [6:0]         r_op;
    logic [6:0]         r_opd;
    logic signed [29:0] r_res;
    logic               r_wv;
    t_word              r_wval;

    // word store
    t_word             mem [MEMORY_WORDS];
    logic [MEMORY_WORDS-1:0] r_valid;
    t_word             r_rd_data;
    logic              r_rd_ok;

    // result beat
    logic [6:0] r_o_pc;
    t_word      r_o_acc;
    logic [2:0] r_o_status;
    logic       r_o_wv;
    t_word      r_o_wval;
    t_word      r_o_rdata;

    logic [6:0]         rd_addr;
    logic               rd_in;
    logic [AW-1:0]      rd_idx;
    t_word              mem_eff;
    logic               wr_en;
    logic [6:0]         wr_addr;
    t_word              wr_data;
    logic               wr_ok;
    logic [26:0]        recip_prod;
    logic [MAG_W-1:0]   q_hund;
    logic signed [29:0] acc_x;
    logic signed [29:0] m_x;
    logic signed [29:0] exec_res;
    logic [PC_W-1:0]    next_pc;
    logic               res_ovf;
    logic               div_done;
    t_word              div_q;

    function automatic t_word clamp_word(input t_word v);
        if (v > WORD_MAX) begin
            return WORD_MAX;
        end else if (v < WORD_MIN) begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RS_ADDR: rd_addr = r_addr;
            RS_PC:   rd_addr = r_pc;
            RS_OPD:  rd_addr = r_opd;
            default: rd_addr = r_addr;
        endcase
        rd_in   = rd_addr < MEM_N;
        rd_idx  = rd_addr[AW-1:0];
        mem_eff = r_rd_ok ? r_rd_data : '0;
    end

    // write port select: load request, or read/store instruction
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = r_word;
        if (i_cmd.load_we) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit && r_op == OP_READ) begin
            wr_en   = 1'b1;
            wr_addr = r_opd;
            wr_data = r_rin;
        end else if (i_cmd.commit && r_op == OP_STORE) begin
            wr_en   = 1'b1;
            wr_addr = r_opd;
            wr_data = r_acc;
        end
        wr_ok = wr_en && (wr_addr < MEM_N);
    end

    // memory array and registered read
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_idx];
        end
    end

    // valid bits: unwritten words read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_valid[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_ok <= rd_in && r_valid[rd_idx];
            end
        end
    end

    // opcode and operand split by reciprocal multiply
    always_comb begin
        recip_prod = 27'(mem_eff[MAG_W-1:0]) * 27'(RECIP_100);
        q_hund     = 14'(r_q) * HUNDRED;
    end

    // arithmetic result
    always_comb begin
        acc_x = 30'(r_acc);
        m_x   = 30'(mem_eff);
        case (r_op)
            OP_LOAD: exec_res = m_x;
            OP_ADD:  exec_res = acc_x + m_x;
            OP_SUB:  exec_res = acc_x - m_x;
            OP_MUL:  exec_res = acc_x * m_x;
            default: exec_res = acc_x;
        endcase
    end

    // next pc and range check
    always_comb begin
        next_pc = 7'(r_pc + 7'd1);
        if (r_op == OP_BRANCH
            || (r_op == OP_BRANCHNEG && r_res < 0)
            || (r_op == OP_BRANCHZERO && r_res == 0)) begin
            next_pc = r_opd;
        end
        res_ovf = (r_res > 30'(WORD_MAX)) || (r_res < 30'(WORD_MIN));
    end

    dam_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_acc),
        .i_divisor  (mem_eff),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_pc     <= '0;
            r_status <= ST_RUN;
        end else if (i_cmd.restart) begin
            r_acc    <= '0;
            r_pc     <= '0;
            r_status <= ST_RUN;
        end else if (i_cmd.ranoff) begin
            r_status <= ST_RANOFF;
        end else if (i_cmd.divz) begin
            r_status <= ST_DIVZ;
        end else if (i_cmd.commit) begin
            r_pc <= next_pc;
            if (r_op == OP_HALT) begin
                r_status <= ST_HALT;
            end else if (res_ovf) begin
                r_status <= ST_OVF;
            end else begin
                r_acc <= 15'(r_res);
                if (next_pc >= MEM_N) begin
                    r_status <= ST_RANOFF;
                end
            end
        end
    end

    // request latch, decode and execution registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_addr <= i_address;
            r_word <= clamp_word(i_word);
            r_rin  <= clamp_word(i_read_input);
            r_wv   <= 1'b0;
            r_wval <= '0;
        end
        if (i_cmd.decode) begin
            // negative words decode as opcode zero, a no-op
            r_w <= mem_eff[WORD_W-1] ? '0 : mem_eff[MAG_W-1:0];
            r_q <= mem_eff[WORD_W-1] ? '0 : recip_prod[RECIP_SH+6:RECIP_SH];
        end
        if (i_cmd.split) begin
            r_op  <= r_q;
            r_opd <= 7'(r_w - q_hund);
        end
        if (i_cmd.exec) begin
            r_res <= exec_res;
            if (r_op == OP_WRITE) begin
                r_wv   <= 1'b1;
                r_wval <= mem_eff;
            end
        end
        if (i_cmd.div_take) begin
            r_res <= 30'(div_q);
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_pc     <= r_pc;
            r_o_acc    <= r_acc;
            r_o_status <= r_status;
            r_o_wv     <= r_wv;
            r_o_wval   <= r_wval;
            r_o_rdata  <= (r_mode == MODE_READ) ? mem_eff : '0;
        end
    end

    // status to controller
    always_comb begin
        o_sts.mode     = r_mode;
        o_sts.running  = r_status == ST_RUN;
        o_sts.pc_ok    = r_pc < MEM_N;
        o_sts.is_div   = r_op == OP_DIV;
        o_sts.m_zero   = mem_eff == '0;
        o_sts.div_done = div_done;
    end

    assign o_program_counter = r_o_pc;
    assign o_accumulator     = r_o_acc;
    assign o_status          = r_o_status;
    assign o_write_valid     = r_o_wv;
    assign o_write_value     = r_o_wval;
    assign o_read_data       = r_o_rdata;

endmodule

@@ src/dam_ctrl.sv @@
module dam_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  dam_pkg::t_sts i_sts,
    output dam_pkg::t_cmd o_cmd
);
    import dam_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FETCH  = 9'b000000010,
        S_DECODE = 9'b000000100,
        S_SPLIT  = 9'b000001000,
        S_OPER   = 9'b000010000,
        S_EXEC   = 9'b000100000,
        S_DIV    = 9'b001000000,
        S_COMMIT = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // sequencing of one request
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = RS_ADDR;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_FINISH;
                case (i_sts.mode)
                    MODE_LOAD: begin
                        o_cmd.load_we = 1'b1;
                    end
                    MODE_READ: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RS_ADDR;
                    end
                    MODE_RESTART: begin
                        o_cmd.restart = 1'b1;
                    end
                    MODE_EXEC: begin
                        if (i_sts.running && !i_sts.pc_ok) begin
                            o_cmd.ranoff = 1'b1;
                        end else if (i_sts.running) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RS_PC;
                            n_state      = S_DECODE;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_OPER;
            end
            S_OPER: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_OPD;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.is_div && i_sts.m_zero) begin
                    o_cmd.divz = 1'b1;
                    n_state    = S_FINISH;
                end else if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_COMMIT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result beat valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

@@ src/decimal_accumulator_machine_core.sv @@
// decimal accumulator machine: 100 signed four-digit words, one accumulator,
// one program counter and a run status
// input channel (i_in_valid / o_in_ready) carries one request per beat:
// load a word, execute one instruction, read a word back, or restart
// output channel (o_out_valid / i_out_ready) returns one result beat per
// request: pc, accumulator, status, write output and read data
// sequence from accept to result valid:
//   load, read, restart, or execute while stopped: fetch, then finish
//   execute: fetch, decode by reciprocal multiply, operand split, operand
//   read, execute, commit, finish; a divide runs between execute and commit
//   through a one-bit-per-cycle restoring divider; a divide by zero goes
//   from execute straight to finish
// one request is in flight at a time; a new one can be taken in the same
// cycle that the previous result reaches the output register, even while
// that beat is still stalled; a stalled receiver holds the result beat and
// stops the block before its next result is written
// reset clears pc, accumulator and status, and marks every word as zero
// through per-word valid bits, so no clearing pass is needed
module decimal_accumulator_machine_core #(
    parameter int MEMORY_WORDS = 100
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_mode,
    input  logic [6:0]     i_address,
    input  dam_pkg::t_word i_word,
    input  dam_pkg::t_word i_read_input,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [6:0]     o_program_counter,
    output dam_pkg::t_word o_accumulator,
    output logic [2:0]     o_status,
    output logic           o_write_valid,
    output dam_pkg::t_word o_write_value,
    output dam_pkg::t_word o_read_data
);
    import dam_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    dam_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // word store, registers and arithmetic
    dam_dpath #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_address         (i_address),
        .i_word            (i_word),
        .i_read_input      (i_read_input),
        .o_program_counter (o_program_counter),
        .o_accumulator     (o_accumulator),
        .o_status          (o_status),
        .o_write_valid     (o_write_valid),
        .o_write_value     (o_write_value),
        .o_read_data       (o_read_data)
    );

    // one request in flight: accept closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a request was in flight");

    // accumulator never leaves the word range
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_accumulator <= WORD_MAX && o_accumulator >= WORD_MIN))
        else $error("accumulator out of word range");

    // a write instruction never ends in halt, divide by zero or overflow
    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_valid) |-> (o_status == ST_RUN || o_status == ST_RANOFF))
        else $error("write output with an error status");

    // read data and write output come from different modes
    a_read_vs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_data != '0) |-> !o_write_valid)
        else $error("read data and write output in one beat");

endmodule
